/* hdl/cdid_pkg.sv */
// Shared types and constants for the disc ID block.
package cdid_pkg;

    localparam int OFFSET_W     = 19;   // frame offset width
    localparam int SEC_W        = 19;   // whole seconds, worst case one frame per second
    localparam int DIGITS       = 6;    // decimal digits of the largest seconds value
    localparam int DSUM_W       = 6;    // digit sum of DIGITS digits, at most 54
    localparam int TOTAL_W      = 8;    // running total, kept below 255
    localparam int LEN_W        = 16;
    localparam int COUNT_W      = 8;
    localparam int ID_W         = 32;
    localparam int DEFAULT_FPS  = 75;
    localparam int RECIP_W      = 21;   // frames-to-seconds reciprocal width
    localparam int QUEUE_DEPTH  = 4;    // power of two

    // floor(v / 10) = (v * DIV10_RECIP) >> DIV10_SHIFT for any SEC_W-bit v
    localparam int DIV10_SHIFT  = SEC_W + 4;
    localparam int DIV10_W      = 20;
    localparam logic [DIV10_W-1:0] DIV10_RECIP =
        DIV10_W'(((64'd1 << DIV10_SHIFT) + 64'd9) / 64'd10);

    localparam logic [TOTAL_W-1:0] TOTAL_MOD = 8'hFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    typedef enum logic {
        KIND_TRACK   = 1'b0,
        KIND_LEADOUT = 1'b1
    } t_kind;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset_frames;
        t_kind               kind;
    } t_item;

endpackage

/* hdl/cdid_front.sv */
// Front end: takes offset items, tags them as track or lead-out, and queues them.
module cdid_front import cdid_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [OFFSET_W-1:0] i_offset_frames,
    input  logic                i_is_leadout,
    output logic                o_item_valid,
    output t_item               o_item,
    input  logic                i_item_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               push;
    logic               pop;
    t_item              new_item;

    assign o_ready      = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];
    assign push         = i_valid && o_ready;
    assign pop          = i_item_pop && o_item_valid;

    always_comb begin
        new_item.offset_frames = i_offset_frames;
        new_item.kind          = i_is_leadout ? KIND_LEADOUT : KIND_TRACK;
        n_wr_ptr = push ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= new_item;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue count missed a push");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr == r_rd_ptr) |-> (r_count == '0 || r_count == CNT_W'(QUEUE_DEPTH)))
        else $error("queue pointers disagree with count");

endmodule

/* hdl/cdid_back.sv */
// Back end: seconds conversion, digit-sum pipeline, accumulation and ID output.
module cdid_back import cdid_pkg::*; #(
    parameter int FRAMES_PER_SECOND = DEFAULT_FPS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_item_valid,
    input  t_item           i_item,
    output logic            o_item_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [ID_W-1:0] o_disc_id
);

    // floor(f / FPS) = (f * SEC_RECIP) >> SEC_SHIFT for any OFFSET_W-bit f
    localparam int SEC_SHIFT = OFFSET_W + $clog2(FRAMES_PER_SECOND);
    localparam logic [RECIP_W-1:0] SEC_RECIP = RECIP_W'(
        ((64'd1 << SEC_SHIFT) + 64'(FRAMES_PER_SECOND) - 64'd1) / 64'(FRAMES_PER_SECOND));
    // products wide enough that the quotient field lies fully inside them
    localparam int PROD_W = SEC_SHIFT + SEC_W;
    localparam int QPROD_W = DIV10_SHIFT + SEC_W;

    logic                       en;

    // conversion stage
    logic                       r_a_val;
    logic                       r_a_lead;
    logic [PROD_W-1:0]          r_a_prod;
    logic [SEC_W-1:0]           a_secs;
    logic [QPROD_W-1:0]         a_qprod;

    // digit stages: index j holds the value after j digits are peeled off
    logic                       r_val   [DIGITS+1];
    logic                       r_lead  [DIGITS+1];
    logic [LEN_W-1:0]           r_sec16 [DIGITS+1];
    logic [DSUM_W-1:0]          r_sum   [DIGITS+1];
    logic [SEC_W-1:0]           r_v     [DIGITS];
    logic [SEC_W-1:0]           r_q     [DIGITS];

    // accumulator
    logic [TOTAL_W-1:0]         r_total;
    logic [COUNT_W-1:0]         r_count;
    logic [LEN_W-1:0]           r_first;
    logic                       r_out_valid;
    logic [ID_W-1:0]            r_out_id;
    logic                       acc_fire;
    logic                       acc_lead;
    logic [TOTAL_W:0]           total_sum;
    logic [TOTAL_W-1:0]         total_mod;
    logic [LEN_W-1:0]           len;

    assign en         = !r_out_valid || i_ready;
    assign o_item_pop = en && i_item_valid;
    assign o_valid    = r_out_valid;
    assign o_disc_id  = r_out_id;

    assign a_secs  = r_a_prod[SEC_SHIFT +: SEC_W];
    assign a_qprod = QPROD_W'(a_secs) * QPROD_W'(DIV10_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_val <= 1'b0;
            r_val[0] <= 1'b0;
        end else if (en) begin
            r_a_val <= o_item_pop;
            r_val[0] <= r_a_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_lead   <= (i_item.kind == KIND_LEADOUT);
            r_a_prod   <= PROD_W'(i_item.offset_frames) * PROD_W'(SEC_RECIP);
            r_lead[0]  <= r_a_lead;
            r_sec16[0] <= a_secs[LEN_W-1:0];
            r_sum[0]   <= '0;
            r_v[0]     <= a_secs;
            r_q[0]     <= a_qprod[DIV10_SHIFT +: SEC_W];
        end
    end

    for (genvar j = 1; j <= DIGITS; j++) begin : g_digit
        logic [SEC_W+3:0]   ten_q;
        logic [SEC_W+3:0]   diff;
        logic [3:0]         digit;

        assign ten_q = {r_q[j-1], 3'b000} + {2'b00, r_q[j-1], 1'b0};
        assign diff  = {4'b0000, r_v[j-1]} - ten_q;
        assign digit = diff[3:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[j] <= 1'b0;
            end else if (en) begin
                r_val[j] <= r_val[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_lead[j]  <= r_lead[j-1];
                r_sec16[j] <= r_sec16[j-1];
                r_sum[j]   <= r_sum[j-1] + DSUM_W'(digit);
            end
        end

        if (j < DIGITS) begin : g_next
            logic [QPROD_W-1:0] qprod;

            assign qprod = QPROD_W'(r_q[j-1]) * QPROD_W'(DIV10_RECIP);

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_v[j] <= r_q[j-1];
                    r_q[j] <= qprod[DIV10_SHIFT +: SEC_W];
                end
            end
        end
    end

    always_comb begin
        acc_fire  = en && r_val[DIGITS];
        acc_lead  = r_lead[DIGITS];
        total_sum = {1'b0, r_total} + (TOTAL_W+1)'(r_sum[DIGITS]);
        total_mod = (total_sum >= (TOTAL_W+1)'(TOTAL_MOD))
                  ? TOTAL_W'(total_sum - (TOTAL_W+1)'(TOTAL_MOD))
                  : total_sum[TOTAL_W-1:0];
        len       = (r_count != '0) ? r_sec16[DIGITS] - r_first : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_count     <= '0;
            r_first     <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= acc_fire && acc_lead;
            if (acc_fire) begin
                if (acc_lead) begin
                    r_total <= '0;
                    r_count <= '0;
                    r_first <= '0;
                end else begin
                    if (r_count == '0) begin
                        r_first <= r_sec16[DIGITS];
                    end
                    r_total <= total_mod;
                    if (r_count != COUNT_MAX) begin
                        r_count <= r_count + COUNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && acc_fire && acc_lead) begin
            r_out_id <= {r_total, len, r_count};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total != TOTAL_MOD)
        else $error("digit total not reduced");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_fire && acc_lead) |=> (r_count == '0 && r_total == '0 && r_out_valid))
        else $error("lead-out did not clear state or raise result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(acc_fire && acc_lead))
        else $error("result without a lead-out item");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> ($stable(r_count) && $stable(r_total)))
        else $error("accumulator moved while result stalled");

endmodule

/* hdl/cddb_disc_id.sv */
// Top level of the disc ID block: front queue and back pipeline.
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_ready   i_offset_frames[18:0], i_is_leadout
//   result    out        o_valid / i_ready   o_disc_id[31:0]
//
// One item per cycle sustained while the result is not stalled; a lead-out result
// passes the seconds multiply, the tens quotient, one stage per decimal digit and
// the accumulator with output register before it is presented.
// Synchronous active-low reset clears the queue, the pipeline and the disc state.
// A stalled result freezes the back pipeline; the 4-entry queue keeps taking
// items until full.
module cddb_disc_id import cdid_pkg::*; #(
    parameter int FRAMES_PER_SECOND = DEFAULT_FPS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [OFFSET_W-1:0] i_offset_frames,
    input  logic                i_is_leadout,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [ID_W-1:0]     o_disc_id
);

    logic   item_valid;
    t_item  item;
    logic   item_pop;

    cdid_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_offset_frames (i_offset_frames),
        .i_is_leadout    (i_is_leadout),
        .o_item_valid    (item_valid),
        .o_item          (item),
        .i_item_pop      (item_pop)
    );

    cdid_back #(
        .FRAMES_PER_SECOND (FRAMES_PER_SECOND)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_pop   (item_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_disc_id    (o_disc_id)
    );

endmodule

/* test/cddb_disc_id_tb.sv */
// Self-checking testbench for the disc ID block: directed table, then random discs.
`timescale 1ns / 100ps

module cddb_disc_id_tb;
    import cdid_pkg::*;

    localparam int          FPS         = DEFAULT_FPS;
    localparam int          LATENCY     = DIGITS + 4;
    localparam int          RAND_ITEMS  = 1550;
    localparam int          LONG_HOLD   = 400;
    localparam int unsigned OFFSET_MAX  = (1 << OFFSET_W) - 1;

    // idle/stall phases
    typedef enum int {
        PH_STEADY,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH_LIGHT
    } t_phase;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        t_kind               kind;
        logic                fixed;
        logic [ID_W-1:0]     id;
    } t_toc_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [OFFSET_W-1:0] i_offset_frames = '0;
    logic                i_is_leadout = 1'b0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [ID_W-1:0]     o_disc_id;

    // running disc state of the predictor
    logic [TOTAL_W-1:0]  digit_acc = '0;
    logic [COUNT_W-1:0]  tracks_seen = '0;
    logic [15:0]         first_secs = '0;

    logic [ID_W-1:0]     pending_ids[$];
    t_phase              phase = PH_STEADY;
    int                  hold_cycles = 0;
    int                  mismatch_count = 0;
    int                  ids_checked = 0;
    int                  offsets_sent = 0;
    int                  discs_sent = 0;

    // Directed table of contents; ids typed in where obvious, else predicted.
    t_toc_row toc_rows [0:18] = '{
        '{19'd0,      KIND_LEADOUT, 1'b1, 32'h0000_0000},  // empty disc
        '{19'h7FFFF,  KIND_LEADOUT, 1'b1, 32'h0000_0000},
        '{19'd0,      KIND_TRACK,   1'b0, 32'h0},
        '{19'd0,      KIND_LEADOUT, 1'b1, 32'h0000_0001},
        '{19'h7FFFF,  KIND_TRACK,   1'b0, 32'h0},
        '{19'h7FFFF,  KIND_LEADOUT, 1'b1, 32'h1800_0001},  // 6990 s, digits 24
        '{19'h7FFFF,  KIND_TRACK,   1'b0, 32'h0},
        '{19'd0,      KIND_LEADOUT, 1'b1, 32'h18E4_B201},  // lead-out below track: wraps
        '{19'd74,     KIND_TRACK,   1'b0, 32'h0},
        '{19'd75,     KIND_TRACK,   1'b0, 32'h0},
        '{19'd150,    KIND_LEADOUT, 1'b1, 32'h0100_0202},
        '{19'd150,    KIND_TRACK,   1'b0, 32'h0},
        '{19'd18000,  KIND_TRACK,   1'b0, 32'h0},
        '{19'd41234,  KIND_TRACK,   1'b0, 32'h0},
        '{19'd90075,  KIND_TRACK,   1'b0, 32'h0},
        '{19'd333333, KIND_LEADOUT, 1'b0, 32'h0},
        '{19'h2AAAA,  KIND_TRACK,   1'b0, 32'h0},
        '{19'h55555,  KIND_TRACK,   1'b0, 32'h0},
        '{19'h55555,  KIND_LEADOUT, 1'b0, 32'h0}
    };

    cddb_disc_id #(
        .FRAMES_PER_SECOND (FPS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_offset_frames (i_offset_frames),
        .i_is_leadout    (i_is_leadout),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_disc_id       (o_disc_id)
    );

    always #4 i_clk = ~i_clk;

    function automatic int secs_digit_sum(input int unsigned secs);
        int sum;
        sum = 0;
        while (secs > 0) begin
            sum += secs % 10;
            secs /= 10;
        end
        return sum;
    endfunction

    // Advance the disc state by one offset; returns 1 with the ID on a lead-out.
    function automatic bit disc_id_step(input logic [OFFSET_W-1:0] frames, input t_kind kind,
                                        output logic [ID_W-1:0] id);
        int unsigned secs;
        logic [15:0] play_len;
        secs = frames / FPS;
        id = '0;
        if (kind == KIND_TRACK) begin
            if (tracks_seen == 0)
                first_secs = 16'(secs);
            digit_acc = TOTAL_W'((int'(digit_acc) + secs_digit_sum(secs)) % int'(TOTAL_MOD));
            if (tracks_seen != COUNT_MAX)
                tracks_seen++;
            return 1'b0;
        end
        play_len = (tracks_seen != 0) ? 16'(secs) - first_secs : 16'd0;
        id = {digit_acc, play_len, tracks_seen};
        digit_acc = '0;
        tracks_seen = '0;
        first_secs = '0;
        return 1'b1;
    endfunction

    function automatic bit roll_idle(input bit sender);
        int pct;
        pct = 0;
        if (phase == PH_BOTH_LIGHT)
            pct = 7;
        else if ((sender && phase == PH_SEND_IDLE) || (!sender && phase == PH_RECV_STALL))
            pct = 75;
        return $urandom_range(0, 99) < pct;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_offset(input int unsigned frames, input t_kind kind,
                               input logic fixed = 1'b0, input logic [ID_W-1:0] fixed_id = '0);
        logic [ID_W-1:0] id;
        while (roll_idle(1'b1)) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_offset_frames <= OFFSET_W'(frames);
        i_is_leadout    <= (kind == KIND_LEADOUT);
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        offsets_sent++;
        if (disc_id_step(OFFSET_W'(frames), kind, id))
            pending_ids.push_back(fixed ? fixed_id : id);
        @(negedge i_clk);
    endtask

    // Orderly discs have rising offsets; otherwise offsets are arbitrary.
    task automatic send_disc(input int tracks, input bit orderly);
        int unsigned pos;
        int unsigned room;
        pos = orderly ? $urandom_range(0, 450) : $urandom_range(0, OFFSET_MAX);
        for (int t = 0; t < tracks; t++) begin
            send_offset(pos, KIND_TRACK);
            if (orderly) begin
                room = (OFFSET_MAX - pos) / (tracks - t + 1);
                pos += $urandom_range(1, (room > 1) ? room : 1);
                if (pos > OFFSET_MAX)
                    pos = OFFSET_MAX;
            end else begin
                pos = $urandom_range(0, OFFSET_MAX);
            end
        end
        if (orderly)
            pos += $urandom_range(0, OFFSET_MAX - pos);
        else
            pos = $urandom_range(0, OFFSET_MAX);
        send_offset(pos, KIND_LEADOUT);
        discs_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_ids.size() != 0)
            @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // receiver side
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_ready     <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_ready <= !roll_idle(1'b0);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        logic [ID_W-1:0] want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_ids.size() == 0) begin
                $error("disc_id: unexpected item 0x%08h", o_disc_id);
                mismatch_count++;
            end else begin
                want = pending_ids.pop_front();
                ids_checked++;
                if (o_disc_id !== want) begin
                    $error("disc_id: expected 0x%08h, got 0x%08h", want, o_disc_id);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("cddb_disc_id regression: fail");
        $finish;
    end

    initial begin
        int start_count;
        int pick;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (toc_rows[r])
            send_offset(toc_rows[r].offset, toc_rows[r].kind, toc_rows[r].fixed, toc_rows[r].id);
        wait_drained();

        // long receiver hold-off while short discs keep coming: input must back up
        @(posedge i_clk);
        hold_cycles = LONG_HOLD;
        @(negedge i_clk);
        repeat (16)
            send_disc(1, 1'b1);
        // track count saturates past 255 while digits keep summing
        send_disc(300, 1'b1);
        wait_drained();

        start_count = offsets_sent;
        while (offsets_sent - start_count < RAND_ITEMS) begin
            phase = t_phase'((discs_sent / 6) % 4);
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_disc($urandom_range(1, 24), 1'b1);
            else if (pick < 90)
                send_disc($urandom_range(0, 8), 1'b0);
            else if (pick < 99)
                send_disc(0, 1'b0);
            else
                send_disc($urandom_range(256, 300), 1'b1);
        end
        wait_drained();

        $display("Sent %0d offsets in %0d discs; checked %0d disc IDs.",
                 offsets_sent, discs_sent, ids_checked);
        $display("Covered field extremes, empty and wrapped discs, saturated counts, stalls.");
        if (mismatch_count == 0)
            $display("cddb_disc_id regression: pass");
        else
            $display("cddb_disc_id regression: fail");
        $finish;
    end

endmodule
